@@ rtl/assert_macros.svh @@
// Assertion macros used by the serializer top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/cfbs_pkg.sv @@
// Types, codes and constants of the CAN frame binary serializer.
package cfbs_pkg;

  localparam logic [7:0]  RECORD_MARK     = 8'hF1;
  localparam logic [31:0] EXT_FLAG        = 32'h8000_0000;
  localparam logic [3:0]  NIBBLE          = 4'hF;
  localparam logic [4:0]  RECORD_OVERHEAD = 5'd12;
  localparam logic [3:0]  MAX_DATA        = 4'd8;
  localparam int          REC_BYTES       = 20;
  localparam int          REC_W           = REC_BYTES * 8;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_RAW    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_IGNORE = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] timestamp_us;
    logic [28:0] can_id;
    logic        extended;
    logic [3:0]  length_code;
    logic [3:0]  bus_number;
    logic [63:0] payload;
    logic [7:0]  raw_byte;
  } in_req_t;

  typedef struct packed {
    logic        write_valid;
    logic [10:0] write_address;
    logic [7:0]  write_byte;
    logic        frame_dropped;
    logic        last;
    logic [11:0] fill_after;
    logic [31:0] drops_total;
  } out_res_t;

  // Sequencer to record shifter.
  typedef struct packed {
    logic load;
    logic advance;
  } rec_ctrl_t;

  // Record shifter back to sequencer.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       final_byte;
  } rec_stat_t;

  // Data byte count: length code above eight counts as eight.
  function automatic logic [3:0] clamp_len(input logic [3:0] dlc);
    logic [3:0] n;
    n = dlc & NIBBLE;
    if (n > MAX_DATA) begin
      n = MAX_DATA;
    end
    return n;
  endfunction

endpackage

@@ rtl/cfbs_record_shifter.sv @@
// Frame record shift register: loads a whole record, shifts out one byte per advance.
module cfbs_record_shifter
  import cfbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   req,
  input  rec_ctrl_t ctrl,
  output rec_stat_t stat
);

  logic [REC_W-1:0] rec_r;
  logic [REC_W-1:0] rec_nxt;
  logic [4:0]       cnt_r;
  logic [4:0]       cnt_nxt;
  logic [REC_W-1:0] rec_load;
  logic [63:0]      data_masked;
  logic [31:0]      id_word;
  logic [3:0]       n;

  always_comb begin
    n = clamp_len(req.length_code);
    for (int i = 0; i < 8; i++) begin
      data_masked[8*i +: 8] = (4'(i) < n) ? req.payload[8*i +: 8] : 8'h00;
    end
    id_word = {3'b000, req.can_id} | (req.extended ? EXT_FLAG : 32'h0);
    // Bytes past the data are zero, so the trailing zero byte comes for free.
    rec_load = {8'h00, data_masked, req.bus_number, n, id_word,
                req.timestamp_us, 8'h00, RECORD_MARK};
  end

  always_comb begin
    rec_nxt = rec_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      rec_nxt = rec_load;
      cnt_nxt = RECORD_OVERHEAD + {1'b0, n} - 5'd1;
    end else if (ctrl.advance) begin
      rec_nxt = {8'h00, rec_r[REC_W-1:8]};
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.byte_val   = rec_r[7:0];
  assign stat.final_byte = (cnt_r == 5'd0);

endmodule

@@ rtl/can_frame_binary_serializer.sv @@
// CAN frame binary serializer: turns frame, raw byte and clear requests into buffer writes.
// Each accepted request is decided in a decide state (space check with a single add and
// compare), then its results go out through an output register, one per cycle while the
// result port takes them. A frame record of 12+N bytes is shifted out of a record shift
// register one byte per cycle, again only while the result port is not stalled. A stalled
// result port holds the flow; in_ready is high only while no request is in progress.
module can_frame_binary_serializer
  import cfbs_pkg::*;
#(
  parameter int BUFFER_BYTES = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [FILL_W-1:0] BUF_LIM  = FILL_W'(BUFFER_BYTES);
  localparam logic [FILL_W:0]   BUF_LIM1 = (FILL_W + 1)'(BUFFER_BYTES);

  state_t          state_r, state_nxt;
  in_req_t         req_r;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [31:0]     drops_r, drops_nxt;
  logic            out_valid_r;
  out_res_t        out_data_r, out_nxt;
  logic            out_load;
  logic            out_free;
  rec_ctrl_t       rec_ctrl;
  rec_stat_t       rec_stat;
  logic [4:0]      rec_size;
  logic [FILL_W:0] fill_sum;
  logic            fits;
  logic            is_frame;
  logic [FILL_W+10:0] addr_ext;
  logic [FILL_W+11:0] fill_nxt_ext;

  cfbs_record_shifter u_shifter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .ctrl  (rec_ctrl),
    .stat  (rec_stat)
  );

  assign out_free = !out_valid_r || out_ready;
  assign is_frame = (req_r.operation == OP_FRAME);
  assign rec_size = RECORD_OVERHEAD + {1'b0, clamp_len(req_r.length_code)};
  assign fill_sum = {1'b0, fill_r} + (FILL_W + 1)'(rec_size);
  assign fits     = (fill_sum < BUF_LIM1);
  assign fill_inc = fill_r + FILL_W'(1);
  assign addr_ext = {11'd0, fill_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (is_frame && fits) begin
          state_nxt = ST_EMIT;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && rec_stat.final_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    rec_ctrl     = '0;
    out_load     = 1'b0;
    out_nxt      = '0;
    fill_nxt     = fill_r;
    drops_nxt    = drops_r;
    fill_nxt_ext = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DECIDE: begin
        out_nxt.last = 1'b1;
        case (req_r.operation)
          OP_FRAME: begin
            if (fits) begin
              rec_ctrl.load = 1'b1;
            end else begin
              drops_nxt             = drops_r + 32'd1;
              out_nxt.frame_dropped = 1'b1;
            end
          end
          OP_RAW: begin
            if (fill_r < BUF_LIM) begin
              out_nxt.write_valid   = 1'b1;
              out_nxt.write_address = addr_ext[10:0];
              out_nxt.write_byte    = req_r.raw_byte;
              fill_nxt              = fill_inc;
            end
          end
          OP_CLEAR: begin
            fill_nxt = '0;
          end
          default: ;
        endcase
        out_load = out_free && !(is_frame && fits);
        fill_nxt_ext        = {12'd0, fill_nxt};
        out_nxt.fill_after  = fill_nxt_ext[11:0];
        out_nxt.drops_total = drops_nxt;
        // Hold state until the single result can be written.
        if (!out_load) begin
          fill_nxt  = fill_r;
          drops_nxt = drops_r;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load              = 1'b1;
          rec_ctrl.advance      = 1'b1;
          fill_nxt              = fill_inc;
          out_nxt.write_valid   = 1'b1;
          out_nxt.write_address = addr_ext[10:0];
          out_nxt.write_byte    = rec_stat.byte_val;
          out_nxt.last          = rec_stat.final_byte;
        end
        fill_nxt_ext        = {12'd0, fill_inc};
        out_nxt.fill_after  = fill_nxt_ext[11:0];
        out_nxt.drops_total = drops_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      drops_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      drops_r <= drops_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "assert_macros.svh"

  `ASSERT_CLK(a_fill_bound, fill_r <= BUF_LIM, "fill level above buffer size")
  `ASSERT_IMPL(a_addr_fill, out_valid_r && out_data_r.write_valid, out_data_r.fill_after[10:0] == 11'(out_data_r.write_address + 11'd1), "fill_after does not follow write address")
  `ASSERT_CLK(a_drop_step, (drops_r == $past(drops_r)) || (drops_r == $past(drops_r) + 32'd1), "drop counter moved by more than one")
  `ASSERT_IMPL(a_emit_busy, state_r == ST_EMIT, !in_ready && !rec_ctrl.load, "request taken while record in flight")

endmodule

@@ bench/tb_can_frame_binary_serializer.sv @@
// Self-checking testbench for the CAN frame binary serializer.
module tb_can_frame_binary_serializer;
  timeunit 1ns;
  timeprecision 1ps;
  import cfbs_pkg::*;

  localparam int BUF_BYTES    = 2048;
  localparam int REC_FIXED    = 12;
  localparam int DATA_MAX     = 8;
  localparam int RANDOM_REQS  = 250;
  localparam int PHASE_LEN    = RANDOM_REQS / 3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_res_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_data;

  int          buf_fill;
  logic [31:0] drop_total;
  out_res_t    pending_writes[$];
  dir_row_t    directed_rows[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 20;
  int          recv_idle_pct = 55;
  bit          hold_off_req = 1'b0;

  can_frame_binary_serializer #(.BUFFER_BYTES(BUF_BYTES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_req_t mk_req(logic [1:0] op, logic [31:0] ts, logic [28:0] id,
                                     logic ext, logic [3:0] dlc, logic [3:0] bus,
                                     logic [63:0] pl, logic [7:0] raw);
    in_req_t r;
    r.operation    = op;
    r.timestamp_us = ts;
    r.can_id       = id;
    r.extended     = ext;
    r.length_code  = dlc;
    r.bus_number   = bus;
    r.payload      = pl;
    r.raw_byte     = raw;
    return r;
  endfunction

  function automatic out_res_t mk_res(logic v, logic [10:0] a, logic [7:0] b, logic d,
                                      logic l, logic [11:0] f, logic [31:0] n);
    out_res_t r;
    r.write_valid   = v;
    r.write_address = a;
    r.write_byte    = b;
    r.frame_dropped = d;
    r.last          = l;
    r.fill_after    = f;
    r.drops_total   = n;
    return r;
  endfunction

  // Tag a write with the fill level and drop count as they stand now.
  function automatic out_res_t pack_write(bit v, int addr, logic [7:0] b, bit dropped,
                                          bit fin);
    return mk_res(v, v ? 11'(addr) : 11'd0, v ? b : 8'h00, dropped, fin,
                  12'(buf_fill), drop_total);
  endfunction

  task automatic predict_writes(input in_req_t req, input bit keep);
    logic [7:0]  rec_bytes [0:19];
    logic [31:0] id_word;
    int          n_data;
    int          n_bytes;
    int          addr;
    int          i;
    out_res_t    res;
    case (req.operation)
      OP_FRAME: begin
        n_data = (int'(req.length_code) > DATA_MAX) ? DATA_MAX : int'(req.length_code);
        if (buf_fill + REC_FIXED + n_data >= BUF_BYTES) begin
          drop_total = drop_total + 32'd1;
          res = pack_write(1'b0, 0, 8'h00, 1'b1, 1'b1);
          if (keep) pending_writes.push_back(res);
        end else begin
          id_word = {3'b000, req.can_id};
          if (req.extended) id_word = id_word | EXT_FLAG;
          rec_bytes[0] = RECORD_MARK;
          rec_bytes[1] = 8'h00;
          for (i = 0; i < 4; i++) begin
            rec_bytes[2 + i] = req.timestamp_us[8*i +: 8];
            rec_bytes[6 + i] = id_word[8*i +: 8];
          end
          rec_bytes[10] = {req.bus_number, 4'(n_data)};
          for (i = 0; i < n_data; i++) rec_bytes[11 + i] = req.payload[8*i +: 8];
          rec_bytes[11 + n_data] = 8'h00;
          n_bytes = REC_FIXED + n_data;
          for (i = 0; i < n_bytes; i++) begin
            addr = buf_fill;
            buf_fill = buf_fill + 1;
            res = pack_write(1'b1, addr, rec_bytes[i], 1'b0, i == n_bytes - 1);
            if (keep) pending_writes.push_back(res);
          end
        end
      end
      OP_RAW: begin
        if (buf_fill < BUF_BYTES) begin
          addr = buf_fill;
          buf_fill = buf_fill + 1;
          res = pack_write(1'b1, addr, req.raw_byte, 1'b0, 1'b1);
        end else begin
          res = pack_write(1'b0, 0, 8'h00, 1'b0, 1'b1);
        end
        if (keep) pending_writes.push_back(res);
      end
      default: begin
        if (req.operation == OP_CLEAR) buf_fill = 0;
        res = pack_write(1'b0, 0, 8'h00, 1'b0, 1'b1);
        if (keep) pending_writes.push_back(res);
      end
    endcase
  endtask

  // Mostly frames; near the top of the buffer mix in raw bytes, clear once full.
  function automatic in_req_t random_req();
    in_req_t q;
    int      roll;
    q = mk_req(OP_FRAME, 32'($urandom), 29'($urandom), 1'($urandom_range(1)),
               4'($urandom_range(1) ? $urandom_range(15) : $urandom_range(15, 8)),
               4'($urandom_range(15)), {32'($urandom), 32'($urandom)}, 8'($urandom));
    roll = int'($urandom_range(99));
    if (buf_fill == BUF_BYTES) begin
      q.operation = (roll < 40) ? OP_CLEAR : (roll < 70) ? OP_RAW : OP_FRAME;
    end else if (buf_fill >= BUF_BYTES - 24) begin
      q.operation = (roll < 50) ? OP_RAW : (roll < 95) ? OP_FRAME : OP_IGNORE;
    end else begin
      q.operation = (roll < 80) ? OP_FRAME : (roll < 94) ? OP_RAW :
                    (roll < 99) ? OP_IGNORE : OP_CLEAR;
    end
    return q;
  endfunction

  task automatic offer_request(input in_req_t req);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic check_write(input out_res_t got);
    out_res_t want;
    if (pending_writes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("%0t: write result with nothing pending: v=%0d a=%0d b=%h", $time,
                 got.write_valid, got.write_address, got.write_byte);
      return;
    end
    want = pending_writes.pop_front();
    if (got.write_valid !== want.write_valid || got.write_address !== want.write_address ||
        got.write_byte !== want.write_byte || got.frame_dropped !== want.frame_dropped ||
        got.last !== want.last || got.fill_after !== want.fill_after ||
        got.drops_total !== want.drops_total) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        $display("%0t: write mismatch", $time);
        $display("  expected v=%0d a=%0d b=%h drop=%0d last=%0d fill=%0d drops=%0d",
                 want.write_valid, want.write_address, want.write_byte, want.frame_dropped,
                 want.last, want.fill_after, want.drops_total);
        $display("  actual   v=%0d a=%0d b=%h drop=%0d last=%0d fill=%0d drops=%0d",
                 got.write_valid, got.write_address, got.write_byte, got.frame_dropped,
                 got.last, got.fill_after, got.drops_total);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_write(out_data);
  end

  // Result side: random stalls, plus one long hold-off to back up the request side.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  initial begin
    int      random_sent;
    bit      hold_done;
    in_req_t req;
    random_sent = 0;
    hold_done   = 1'b0;
    buf_fill    = 0;
    drop_total  = 32'd0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    directed_rows.push_back('{mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_res(0, 0, 8'h00, 0, 1, 0, 0)});
    directed_rows.push_back('{mk_req(OP_IGNORE, '1, '1, 1, '1, '1, '1, '1), 1'b1,
                              mk_res(0, 0, 8'h00, 0, 1, 0, 0)});
    directed_rows.push_back('{mk_req(OP_RAW, 0, 0, 0, 0, 0, 0, 8'hFF), 1'b1,
                              mk_res(1, 0, 8'hFF, 0, 1, 1, 0)});
    directed_rows.push_back('{mk_req(OP_RAW, '1, '1, 1, '1, '1, '1, 8'h00), 1'b1,
                              mk_res(1, 1, 8'h00, 0, 1, 2, 0)});
    directed_rows.push_back('{mk_req(OP_FRAME, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_FRAME, '1, '1, 1, 4'hF, 4'hF, '1, '1), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_FRAME, 32'h1234_5678, 29'h7FF, 0, 4'd8, 4'd0,
                                     64'h0123_4567_89AB_CDEF, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_FRAME, 32'h8000_0000, 29'h1FFF_FFFF, 1, 4'd9, 4'd5,
                                     64'hFEDC_BA98_7654_3210, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_FRAME, 32'h0000_0001, 29'h1000_0000, 0, 4'd1, 4'd8,
                                     64'h0000_0000_0000_00A5, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_FRAME, 32'hDEAD_BEEF, 29'h0ABC_DEF0, 1, 4'd7, 4'd3,
                                     64'h55AA_55AA_55AA_55AA, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RAW, 0, 0, 0, 0, 0, 0, 8'hA5), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_IGNORE, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_CLEAR, '1, '1, 1, '1, '1, '1, '1), 1'b1,
                              mk_res(0, 0, 8'h00, 0, 1, 0, 0)});
    directed_rows.push_back('{mk_req(OP_FRAME, 32'h0F0F_0F0F, 29'h0000_0123, 0, 4'd4, 4'd1,
                                     64'h0000_0000_C3C3_C3C3, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RAW, 0, 0, 0, 0, 0, 0, 8'h5A), 1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      offer_request(directed_rows[k].req);
      predict_writes(directed_rows[k].req, !directed_rows[k].typed);
      if (directed_rows[k].typed) pending_writes.push_back(directed_rows[k].want);
    end

    while (random_sent < RANDOM_REQS) begin
      if (random_sent == PHASE_LEN) begin
        send_idle_pct = 55;
        recv_idle_pct = 20;
      end
      if (random_sent == 2 * PHASE_LEN) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!hold_done) begin
          hold_off_req = 1'b1;
          hold_done    = 1'b1;
        end
      end
      req = random_req();
      offer_request(req);
      predict_writes(req, 1'b1);
      if (req.operation != OP_IGNORE) random_sent++;
    end
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cfbs_pkg.sv
rtl/cfbs_record_shifter.sv
rtl/can_frame_binary_serializer.sv
bench/tb_can_frame_binary_serializer.sv
